// File: sv/bst_pkg.sv
// Shared types, codes and defaults for the breakpoint slot table.
`timescale 1ns / 1ps

package bst_pkg;

  localparam int DEF_SLOTS      = 16;
  localparam int DEF_ADDR_WIDTH = 32;

  localparam int CMD_W    = 2;
  localparam int IN_ADDR_W = 32;
  localparam int SLOTNUM_W = 4;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_NO_FREE   = 3'd1,
    RES_EMPTY     = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_ALLOC     = 3'd4,
    RES_HIT       = 3'd5
  } res_sel_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [IN_ADDR_W-1:0] address;
    logic [SLOTNUM_W-1:0] slot_number;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOTNUM_W-1:0] result_slot;
    logic                 hit;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch_item;
    logic     start_alloc;
    logic     start_walk;
    logic     step;
    logic     alloc_commit;
    logic     free_unlink;
    logic     free_push;
    logic     set_res;
    res_sel_t res_sel;
    logic     load_out;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic free_null;
    logic active_null;
    logic cur_is_want;
    logic next_null;
    logic addr_hit;
  } sts_t;

endpackage

// File: sv/breakpoint_slot_table.sv
// Breakpoint slot table: top level joining the controller and the datapath.
//
// Commands arrive on the in_ channel (valid/stall); each one gives exactly one
// result transfer on the out_ channel. Allocate takes the head of the free list,
// free unlinks a slot from the active list, check searches the active list
// newest first for an address match.
// An allocate reads the free-list head and sets its result in the write state. An
// allocate with no free slot, a free or check on an empty list and the unused
// command are answered directly from the start state. Free and check walk the
// active list one slot per cycle through the link memory read port. One command
// is in work at a time; the next is taken in the cycle after the result has been
// handed to the output register.
// The output register holds a finished result while out_stall is high; the
// block meanwhile accepts and works on the next command, which waits only at
// its own result hand-off.
// Reset puts every slot on the free list in order (slot 0 first), leaves the
// active list empty and drops any pending result. No clearing pass is needed.
`timescale 1ns / 1ps

module breakpoint_slot_table #(
  parameter int SLOTS      = bst_pkg::DEF_SLOTS,
  parameter int ADDR_WIDTH = bst_pkg::DEF_ADDR_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bst_pkg::out_item_t out_data
);

  import bst_pkg::*;

  ctl_t ctl;
  sts_t sts;

  bst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  bst_datapath #(
    .SLOTS      (SLOTS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: sv/bst_datapath.sv
// Datapath: slot link and address memories, list heads, walk pointers and result registers.
`timescale 1ns / 1ps

module bst_datapath #(
  parameter int SLOTS      = 16,
  parameter int ADDR_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bst_pkg::in_item_t  in_data,
  input  bst_pkg::ctl_t      ctl,
  output bst_pkg::sts_t      sts,
  output bst_pkg::out_item_t out_data
);

  import bst_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int CMP_W  = (SLOT_W > SLOTNUM_W) ? SLOT_W : SLOTNUM_W;
  localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

  // Item registers.
  cmd_t                 cmd_r;
  logic [ADDR_WIDTH-1:0] addr_r;
  logic [SLOTNUM_W-1:0] want_r;

  // List heads and walk pointers.
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [LINK_W-1:0] active_head_r, active_head_nxt;
  logic [SLOT_W-1:0] cur_r;
  logic [LINK_W-1:0] prev_r;

  // Memories and their registered read data.
  logic [LINK_W-1:0]     link_mem [SLOTS];
  logic [SLOTS-1:0]      link_vld_r;
  logic [ADDR_WIDTH-1:0] addr_mem [SLOTS];
  logic [LINK_W-1:0]     link_rd_r;
  logic                  link_rd_vld_r;
  logic [ADDR_WIDTH-1:0] addr_rd_r;

  logic [LINK_W-1:0] lnk;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_idx;
  logic              link_we;
  logic [SLOT_W-1:0] link_widx;
  logic [LINK_W-1:0] link_wdata;
  logic              addr_we;
  logic [ADDR_WIDTH-1:0] addr_wdata;

  out_item_t res_r;
  out_item_t res_nxt;
  out_item_t out_r;

  // An entry never written since reset reads as its reset link, the next slot.
  // Reads always target the current slot, so its index stands in for the read address.
  assign lnk = link_rd_vld_r ? link_rd_r : (LINK_W'(cur_r) + LINK_W'(1));

  always_comb begin
    rd_en  = ctl.start_alloc | ctl.start_walk | ctl.step;
    rd_idx = lnk[SLOT_W-1:0];
    if (ctl.start_alloc) begin
      rd_idx = free_head_r[SLOT_W-1:0];
    end else if (ctl.start_walk) begin
      rd_idx = active_head_r[SLOT_W-1:0];
    end
  end

  always_comb begin
    link_we    = 1'b0;
    link_widx  = cur_r;
    link_wdata = active_head_r;
    addr_we    = 1'b0;
    addr_wdata = addr_r;
    if (ctl.alloc_commit) begin
      link_we = 1'b1;
      addr_we = 1'b1;
    end else if (ctl.free_unlink) begin
      link_we    = (prev_r != NIL);
      link_widx  = prev_r[SLOT_W-1:0];
      link_wdata = lnk;
    end else if (ctl.free_push) begin
      link_we    = 1'b1;
      link_wdata = free_head_r;
      addr_we    = 1'b1;
      addr_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      link_rd_r     <= link_mem[rd_idx];
      link_rd_vld_r <= link_vld_r[rd_idx];
      addr_rd_r     <= addr_mem[rd_idx];
    end
    if (link_we) begin
      link_mem[link_widx] <= link_wdata;
    end
    if (addr_we) begin
      addr_mem[cur_r] <= addr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (link_we) begin
      link_vld_r[link_widx] <= 1'b1;
    end
  end

  always_comb begin
    free_head_nxt   = free_head_r;
    active_head_nxt = active_head_r;
    if (ctl.alloc_commit) begin
      free_head_nxt   = lnk;
      active_head_nxt = LINK_W'(cur_r);
    end
    if (ctl.free_unlink && prev_r == NIL) begin
      active_head_nxt = lnk;
    end
    if (ctl.free_push) begin
      free_head_nxt = LINK_W'(cur_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r   <= '0;
      active_head_r <= NIL;
    end else begin
      free_head_r   <= free_head_nxt;
      active_head_r <= active_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      cmd_r  <= cmd_t'(in_data.command);
      addr_r <= ADDR_WIDTH'(in_data.address);
      want_r <= in_data.slot_number;
    end
    if (ctl.start_alloc) begin
      cur_r <= free_head_r[SLOT_W-1:0];
    end else if (ctl.start_walk) begin
      cur_r  <= active_head_r[SLOT_W-1:0];
      prev_r <= NIL;
    end else if (ctl.step) begin
      cur_r  <= lnk[SLOT_W-1:0];
      prev_r <= LINK_W'(cur_r);
    end
  end

  always_comb begin
    res_nxt.status      = ST_OK;
    res_nxt.result_slot = '0;
    res_nxt.hit         = 1'b0;
    unique case (ctl.res_sel)
      RES_OK:        ;
      RES_NO_FREE:   res_nxt.status = ST_NO_FREE;
      RES_EMPTY:     res_nxt.status = ST_EMPTY;
      RES_NOT_FOUND: res_nxt.status = ST_NOT_FOUND;
      RES_ALLOC:     res_nxt.result_slot = SLOTNUM_W'(cur_r);
      RES_HIT: begin
        res_nxt.result_slot = SLOTNUM_W'(cur_r);
        res_nxt.hit         = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.set_res) begin
      res_r <= res_nxt;
    end
    if (ctl.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  assign sts.cmd         = cmd_r;
  assign sts.free_null   = (free_head_r == NIL);
  assign sts.active_null = (active_head_r == NIL);
  assign sts.cur_is_want = (CMP_W'(cur_r) == CMP_W'(want_r));
  assign sts.next_null   = (lnk == NIL);
  assign sts.addr_hit    = (addr_rd_r == addr_r);

endmodule

// File: sv/bst_ctrl.sv
// Controller: sequences allocate, free and check over the slot lists and owns both handshakes.
`timescale 1ns / 1ps

module bst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bst_pkg::sts_t sts,
  output bst_pkg::ctl_t ctl
);

  import bst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_START      = 7'b0000010,
    S_ALLOC_WR   = 7'b0000100,
    S_FREE_WALK  = 7'b0001000,
    S_FREE_PUSH  = 7'b0010000,
    S_CHECK_WALK = 7'b0100000,
    S_FINISH     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.res_sel = RES_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch_item = 1'b1;
          state_nxt      = S_START;
        end
      end
      S_START: begin
        state_nxt = S_FINISH;
        case (sts.cmd)
          CMD_ALLOC: begin
            if (sts.free_null) begin
              ctl.set_res = 1'b1;
              ctl.res_sel = RES_NO_FREE;
            end else begin
              ctl.start_alloc = 1'b1;
              state_nxt       = S_ALLOC_WR;
            end
          end
          CMD_FREE: begin
            if (sts.active_null) begin
              ctl.set_res = 1'b1;
              ctl.res_sel = RES_EMPTY;
            end else begin
              ctl.start_walk = 1'b1;
              state_nxt      = S_FREE_WALK;
            end
          end
          CMD_CHECK: begin
            if (sts.active_null) begin
              ctl.set_res = 1'b1;
            end else begin
              ctl.start_walk = 1'b1;
              state_nxt      = S_CHECK_WALK;
            end
          end
          default: ctl.set_res = 1'b1;
        endcase
      end
      S_ALLOC_WR: begin
        ctl.alloc_commit = 1'b1;
        ctl.set_res      = 1'b1;
        ctl.res_sel      = RES_ALLOC;
        state_nxt        = S_FINISH;
      end
      S_FREE_WALK: begin
        if (sts.cur_is_want) begin
          ctl.free_unlink = 1'b1;
          state_nxt       = S_FREE_PUSH;
        end else if (sts.next_null) begin
          ctl.set_res = 1'b1;
          ctl.res_sel = RES_NOT_FOUND;
          state_nxt   = S_FINISH;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_FREE_PUSH: begin
        ctl.free_push = 1'b1;
        ctl.set_res   = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_CHECK_WALK: begin
        if (sts.addr_hit) begin
          ctl.set_res = 1'b1;
          ctl.res_sel = RES_HIT;
          state_nxt   = S_FINISH;
        end else if (sts.next_null) begin
          ctl.set_res = 1'b1;
          state_nxt   = S_FINISH;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_FINISH: begin
        // The result moves on once the output register is empty or is being drained.
        if (!out_valid_r || !out_stall) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = ctl.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the breakpoint slot table with its own list predictor.
`timescale 1ns / 1ps

module tb;
  import bst_pkg::*;

  localparam int SLOTS          = DEF_SLOTS;
  localparam logic [4:0] NIL_SLOT = 5'(SLOTS);
  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  breakpoint_slot_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor state: the two linked lists and the stored addresses.
  logic [4:0]  slot_link [SLOTS];
  logic [31:0] slot_addr [SLOTS];
  logic [4:0]  active_head;
  logic [4:0]  free_head;

  out_item_t   slot_reply_q[$];
  logic [31:0] addr_pool [8];
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  bit          hold_request = 1'b0;

  function automatic void table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      slot_link[i] = 5'(i + 1);
      slot_addr[i] = '0;
    end
    active_head = NIL_SLOT;
    free_head   = 5'd0;
  endfunction

  // Applies one command to the predicted lists and returns the reply it gives.
  function automatic out_item_t bp_table_apply(in_item_t item);
    out_item_t  res;
    logic [4:0] cur;
    logic [4:0] prev;
    int         n;
    bit         found;
    res   = '0;
    found = 1'b0;
    n     = 0;
    case (item.command)
      CMD_ALLOC: begin
        if (free_head == NIL_SLOT) begin
          res.status = ST_NO_FREE;
        end else begin
          cur = free_head;
          free_head = slot_link[cur];
          slot_link[cur] = active_head;
          active_head = cur;
          slot_addr[cur] = item.address;
          res.result_slot = cur[3:0];
        end
      end
      CMD_FREE: begin
        if (active_head == NIL_SLOT) begin
          res.status = ST_EMPTY;
        end else begin
          prev = NIL_SLOT;
          cur  = active_head;
          while (n < SLOTS && cur != NIL_SLOT && cur != {1'b0, item.slot_number}) begin
            prev = cur;
            cur  = slot_link[cur];
            n++;
          end
          if (cur == NIL_SLOT || cur != {1'b0, item.slot_number}) begin
            res.status = ST_NOT_FOUND;
          end else begin
            if (prev == NIL_SLOT) active_head = slot_link[cur];
            else slot_link[prev] = slot_link[cur];
            slot_link[cur] = free_head;
            slot_addr[cur] = '0;
            free_head = cur;
          end
        end
      end
      CMD_CHECK: begin
        cur = active_head;
        while (n < SLOTS && cur != NIL_SLOT && !found) begin
          if (slot_addr[cur] == item.address) begin
            found = 1'b1;
            res.hit = 1'b1;
            res.result_slot = cur[3:0];
          end else begin
            cur = slot_link[cur];
          end
          n++;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_cmd(cmd_t c, logic [31:0] a, logic [3:0] s);
    in_item_t item;
    item.command     = c;
    item.address     = a;
    item.slot_number = s;
    return item;
  endfunction

  // Picks a slot that is on the predicted active list, or any slot if it is empty.
  function automatic logic [3:0] random_active_slot();
    logic [4:0] cur;
    int         count;
    int         pick;
    count = 0;
    cur = active_head;
    while (cur != NIL_SLOT) begin
      count++;
      cur = slot_link[cur];
    end
    if (count == 0) return 4'($urandom_range(0, 15));
    pick = $urandom_range(0, count - 1);
    cur = active_head;
    repeat (pick) cur = slot_link[cur];
    return cur[3:0];
  endfunction

  // Mostly well-formed commands: frees name live slots, checks look for stored addresses.
  function automatic in_item_t random_cmd();
    int          sel;
    int          addr_src;
    logic [31:0] a;
    logic [3:0]  s;
    sel = $urandom_range(0, 99);
    a   = $urandom;
    s   = 4'($urandom_range(0, 15));
    if (sel < 35) begin
      if ($urandom_range(0, 1) == 0) a = addr_pool[$urandom_range(0, 7)];
      return make_cmd(CMD_ALLOC, a, s);
    end else if (sel < 65) begin
      if ($urandom_range(0, 3) != 0) s = random_active_slot();
      return make_cmd(CMD_FREE, a, s);
    end else if (sel < 95) begin
      addr_src = $urandom_range(0, 4);
      if (addr_src < 3) begin
        if (active_head != NIL_SLOT) a = slot_addr[random_active_slot()];
      end else if (addr_src == 3) begin
        a = addr_pool[$urandom_range(0, 7)];
      end
      return make_cmd(CMD_CHECK, a, s);
    end
    return make_cmd(CMD_RSVD, a, s);
  endfunction

  // Offers one command and returns at the rising edge of its transfer (or after a gap).
  task automatic send_cmd(input in_item_t item);
    bit taken;
    in_valid <= 1'b1;
    in_data  <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    slot_reply_q.push_back(bp_table_apply(item));
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_cmd(make_cmd(CMD_FREE, 32'h0, 4'd0));
    send_cmd(make_cmd(CMD_CHECK, 32'h0, 4'd0));
    send_cmd(make_cmd(CMD_RSVD, 32'hFFFF_FFFF, 4'hF));
    for (int i = 0; i < SLOTS; i++) begin
      case (i)
        0:       send_cmd(make_cmd(CMD_ALLOC, 32'h0000_0000, 4'hF));
        1:       send_cmd(make_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 4'h0));
        5:       send_cmd(make_cmd(CMD_ALLOC, 32'h8000_0001, 4'(i)));
        9:       send_cmd(make_cmd(CMD_ALLOC, 32'h8000_0001, 4'(i)));
        default: send_cmd(make_cmd(CMD_ALLOC, $urandom, 4'(i)));
      endcase
    end
    // The pool is exhausted now.
    send_cmd(make_cmd(CMD_ALLOC, 32'h1234_5678, 4'd0));
    // A duplicated address reports the newer slot.
    send_cmd(make_cmd(CMD_CHECK, 32'h8000_0001, 4'd0));
    send_cmd(make_cmd(CMD_CHECK, 32'h5555_AAAA, 4'd0));
    send_cmd(make_cmd(CMD_FREE, 32'h0, 4'd7));
    send_cmd(make_cmd(CMD_FREE, 32'h0, 4'd7));
    send_cmd(make_cmd(CMD_FREE, 32'hFFFF_FFFF, 4'd15));
    // The oldest slot sits at the tail of the active list.
    send_cmd(make_cmd(CMD_CHECK, 32'h0000_0000, 4'd0));
    send_cmd(make_cmd(CMD_CHECK, 32'hFFFF_FFFF, 4'd0));
  endtask

  task automatic test_random_mix(input int count);
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) addr_pool[i] = $urandom;
    repeat (count) send_cmd(random_cmd());
  endtask

  // The receiver holds off for a long stretch while commands keep coming.
  task automatic test_backpressure(input int count);
    src_gaps = 1'b0;
    hold_request = 1'b1;
    repeat (count) send_cmd(random_cmd());
    src_gaps = 1'b1;
  endtask

  task automatic test_streaming(input int count);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    repeat (count) send_cmd(random_cmd());
  endtask

  // Receiver stall pattern.
  initial begin
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      n = 1;
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!sink_gaps) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        n = $urandom_range(1, 14);
      end
      repeat (n - 1) @(posedge clk);
    end
  end

  // Reply checker; values are stable at the falling edge before the transfer edge.
  always @(negedge clk) begin
    out_item_t exp_reply;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (slot_reply_q.size() == 0) begin
        $display("%0t: unexpected reply, actual status %0d slot %0d hit %0d",
                 $time, out_data.status, out_data.result_slot, out_data.hit);
        fail_count++;
      end else begin
        exp_reply = slot_reply_q.pop_front();
        if (out_data !== exp_reply) begin
          $display("%0t: reply mismatch, expected status %0d slot %0d hit %0d,",
                   $time, exp_reply.status, exp_reply.result_slot, exp_reply.hit,
                   " actual status %0d slot %0d hit %0d",
                   out_data.status, out_data.result_slot, out_data.hit);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(negedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    table_reset();
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(1000);
    test_backpressure(30);
    test_streaming(250);
    in_valid <= 1'b0;
    while (slot_reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bst_pkg.sv
sv/bst_datapath.sv
sv/bst_ctrl.sv
sv/breakpoint_slot_table.sv
sim/tb.sv
